// ----- rtl/core/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and tables of the md5 digest block
// Holds the transfer structs, the controller state type, the initial chaining
// words and the round tables (additive constants, rotations, word order).
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CntW      = 7;
  localparam int unsigned ByteCntW  = 61;

  // initial chaining words, element 0 is word a
  typedef logic [3:0][WordW-1:0] chain_t;
  localparam chain_t ChainIv = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  // padding and block layout
  localparam logic [7:0]       PadMark       = 8'h80;
  localparam logic [AddrW-1:0] LenLoAddr     = 4'd14;
  localparam logic [AddrW-1:0] LenHiAddr     = 4'd15;
  localparam logic [AddrW:0]   LastZeroShort = 5'd13;
  localparam logic [AddrW:0]   LastZeroLong  = 5'd15;
  localparam logic [1:0]       LastWordIdx   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_t;

  // block buffer write port
  typedef struct packed {
    logic                en;
    logic [AddrW-1:0]    addr;
    logic [WordW-1:0]    data;
    logic [NumLanes-1:0] be;
  } wr_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_MARK,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OUT
  } state_e;

  // message word used by round i
  function automatic logic [AddrW-1:0] msg_index(input logic [5:0] i);
    logic [3:0] ii;
    ii = i[3:0];
    case (i[5:4])
      2'd0:    msg_index = ii;
      2'd1:    msg_index = 4'(ii * 4'd5 + 4'd1);
      2'd2:    msg_index = 4'(ii * 4'd3 + 4'd5);
      default: msg_index = 4'(ii * 4'd7);
    endcase
  endfunction

  // left rotation of round i, indexed by {phase, i[1:0]}
  function automatic logic [4:0] rot_amt(input logic [3:0] j);
    case (j)
      4'd0:    rot_amt = 5'd7;
      4'd1:    rot_amt = 5'd12;
      4'd2:    rot_amt = 5'd17;
      4'd3:    rot_amt = 5'd22;
      4'd4:    rot_amt = 5'd5;
      4'd5:    rot_amt = 5'd9;
      4'd6:    rot_amt = 5'd14;
      4'd7:    rot_amt = 5'd20;
      4'd8:    rot_amt = 5'd4;
      4'd9:    rot_amt = 5'd11;
      4'd10:   rot_amt = 5'd16;
      4'd11:   rot_amt = 5'd23;
      4'd12:   rot_amt = 5'd6;
      4'd13:   rot_amt = 5'd10;
      4'd14:   rot_amt = 5'd15;
      default: rot_amt = 5'd21;
    endcase
  endfunction

  // additive constant of round i
  function automatic logic [WordW-1:0] sine_k(input logic [5:0] i);
    case (i)
      6'd0:  sine_k = 32'hd76aa478;
      6'd1:  sine_k = 32'he8c7b756;
      6'd2:  sine_k = 32'h242070db;
      6'd3:  sine_k = 32'hc1bdceee;
      6'd4:  sine_k = 32'hf57c0faf;
      6'd5:  sine_k = 32'h4787c62a;
      6'd6:  sine_k = 32'ha8304613;
      6'd7:  sine_k = 32'hfd469501;
      6'd8:  sine_k = 32'h698098d8;
      6'd9:  sine_k = 32'h8b44f7af;
      6'd10: sine_k = 32'hffff5bb1;
      6'd11: sine_k = 32'h895cd7be;
      6'd12: sine_k = 32'h6b901122;
      6'd13: sine_k = 32'hfd987193;
      6'd14: sine_k = 32'ha679438e;
      6'd15: sine_k = 32'h49b40821;
      6'd16: sine_k = 32'hf61e2562;
      6'd17: sine_k = 32'hc040b340;
      6'd18: sine_k = 32'h265e5a51;
      6'd19: sine_k = 32'he9b6c7aa;
      6'd20: sine_k = 32'hd62f105d;
      6'd21: sine_k = 32'h02441453;
      6'd22: sine_k = 32'hd8a1e681;
      6'd23: sine_k = 32'he7d3fbc8;
      6'd24: sine_k = 32'h21e1cde6;
      6'd25: sine_k = 32'hc33707d6;
      6'd26: sine_k = 32'hf4d50d87;
      6'd27: sine_k = 32'h455a14ed;
      6'd28: sine_k = 32'ha9e3e905;
      6'd29: sine_k = 32'hfcefa3f8;
      6'd30: sine_k = 32'h676f02d9;
      6'd31: sine_k = 32'h8d2a4c8a;
      6'd32: sine_k = 32'hfffa3942;
      6'd33: sine_k = 32'h8771f681;
      6'd34: sine_k = 32'h6d9d6122;
      6'd35: sine_k = 32'hfde5380c;
      6'd36: sine_k = 32'ha4beea44;
      6'd37: sine_k = 32'h4bdecfa9;
      6'd38: sine_k = 32'hf6bb4b60;
      6'd39: sine_k = 32'hbebfbc70;
      6'd40: sine_k = 32'h289b7ec6;
      6'd41: sine_k = 32'heaa127fa;
      6'd42: sine_k = 32'hd4ef3085;
      6'd43: sine_k = 32'h04881d05;
      6'd44: sine_k = 32'hd9d4d039;
      6'd45: sine_k = 32'he6db99e5;
      6'd46: sine_k = 32'h1fa27cf8;
      6'd47: sine_k = 32'hc4ac5665;
      6'd48: sine_k = 32'hf4292244;
      6'd49: sine_k = 32'h432aff97;
      6'd50: sine_k = 32'hab9423a7;
      6'd51: sine_k = 32'hfc93a039;
      6'd52: sine_k = 32'h655b59c3;
      6'd53: sine_k = 32'h8f0ccc92;
      6'd54: sine_k = 32'hffeff47d;
      6'd55: sine_k = 32'h85845dd1;
      6'd56: sine_k = 32'h6fa87e4f;
      6'd57: sine_k = 32'hfe2ce6e0;
      6'd58: sine_k = 32'ha3014314;
      6'd59: sine_k = 32'h4e0811a1;
      6'd60: sine_k = 32'hf7537e82;
      6'd61: sine_k = 32'hbd3af235;
      6'd62: sine_k = 32'h2ad7d2bb;
      default: sine_k = 32'heb86d391;
    endcase
  endfunction

endpackage

// ----- rtl/core/md5_buf_ram.sv -----
// ----------------------------------------------------------------------------
// md5_buf_ram: block buffer memory
// Sixteen 32-bit words, one write port with byte lane enables and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module md5_buf_ram (
  input  logic                          clk_i,
  input  md5_pkg::wr_t                  wr_i,
  input  logic                          rd_en_i,
  input  logic [md5_pkg::AddrW-1:0]     rd_addr_i,
  output logic [md5_pkg::WordW-1:0]     rd_data_o
);
  import md5_pkg::*;

  logic [WordW-1:0] mem_q [NumWords];

  // byte lane write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int l = 0; l < NumLanes; l++) begin
        if (wr_i.be[l]) begin
          mem_q[wr_i.addr][l*8 +: 8] <= wr_i.data[l*8 +: 8];
        end
      end
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/md5_core.sv -----
// ----------------------------------------------------------------------------
// md5_core: compression engine and chaining words
// Runs the 64 rounds one per cycle, fetching each round's message word from
// the block buffer ahead of its round, then folds the result into the chain.
// ----------------------------------------------------------------------------
module md5_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  md5_pkg::core_ctl_t            ctl_i,
  output md5_pkg::core_sts_t            sts_o,
  output logic                          rd_en_o,
  output logic [md5_pkg::AddrW-1:0]     rd_addr_o,
  input  logic [md5_pkg::WordW-1:0]     rd_data_i,
  output md5_pkg::chain_t               chain_o
);
  import md5_pkg::*;

  // schedule: fetch round n at count n, then add its constant, then run the round
  localparam logic [CntW-1:0] CntFetchEnd = 7'd64;
  localparam logic [CntW-1:0] CntKmFirst  = 7'd1;
  localparam logic [CntW-1:0] CntKmLast   = 7'd64;
  localparam logic [CntW-1:0] CntRndFirst = 7'd2;
  localparam logic [CntW-1:0] CntRndLast  = 7'd65;
  localparam logic [CntW-1:0] CntFinal    = 7'd66;

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  chain_t           chain_q;
  logic [WordW-1:0] km_q, km_d;
  logic [WordW-1:0] wa_q, wb_q, wc_q, wd_q;

  logic [CntW-1:0]  kidx, ridx;
  logic [WordW-1:0] f_val, sum, rot, b_new;
  logic [63:0]      dbl;
  logic             km_en, rnd_en, fin;

  // fetch address and round datapath
  always_comb begin
    kidx    = cnt_q - CntKmFirst;
    ridx    = cnt_q - CntRndFirst;
    rd_en_o = busy_q && (cnt_q < CntFetchEnd);
    rd_addr_o = msg_index(cnt_q[5:0]);
    km_en   = busy_q && (cnt_q >= CntKmFirst) && (cnt_q <= CntKmLast);
    rnd_en  = busy_q && (cnt_q >= CntRndFirst) && (cnt_q <= CntRndLast);
    fin     = busy_q && (cnt_q == CntFinal);
    km_d    = sine_k(kidx[5:0]) + rd_data_i;
    case (ridx[5:4])
      2'd0:    f_val = (wb_q & wc_q) | (~wb_q & wd_q);
      2'd1:    f_val = (wb_q & wd_q) | (wc_q & ~wd_q);
      2'd2:    f_val = wb_q ^ wc_q ^ wd_q;
      default: f_val = wc_q ^ (wb_q | ~wd_q);
    endcase
    sum   = wa_q + f_val + km_q;
    dbl   = {sum, sum} << rot_amt({ridx[5:4], ridx[1:0]});
    rot   = dbl[63:32];
    b_new = wb_q + rot;
  end

  // control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      chain_q <= ChainIv;
    end else begin
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
      end
      if (ctl_i.init) begin
        chain_q <= ChainIv;
      end else if (fin) begin
        chain_q[0] <= chain_q[0] + wa_q;
        chain_q[1] <= chain_q[1] + wb_q;
        chain_q[2] <= chain_q[2] + wc_q;
        chain_q[3] <= chain_q[3] + wd_q;
      end
    end
  end

  // working words and constant-plus-message stage
  always_ff @(posedge clk_i) begin
    if (km_en) begin
      km_q <= km_d;
    end
    if (ctl_i.start) begin
      wa_q <= chain_q[0];
      wb_q <= chain_q[1];
      wc_q <= chain_q[2];
      wd_q <= chain_q[3];
    end else if (rnd_en) begin
      wa_q <= wd_q;
      wd_q <= wc_q;
      wc_q <= wb_q;
      wb_q <= b_new;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = fin;
  assign chain_o    = chain_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("compression started while busy");

  a_single_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> !busy_q) else $error("engine still busy after final fold");

  a_init_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.init |-> !busy_q) else $error("chain reset during compression");

endmodule

// ----- rtl/core/md5_message_digest.sv -----
// ----------------------------------------------------------------------------
// md5_message_digest: md5 digest of a byte stream
// Gathers message bytes into the block buffer, pads at message end and
// returns the four chaining words as four output transfers.
// ----------------------------------------------------------------------------
// A message byte is taken in each idle cycle with valid input. After every
// 64th byte the input stalls while the block is compressed: one round a cycle
// over the single read port of the block buffer, then the final fold. At
// message end the pad and length words are written one per cycle, with a turn
// state after each zero fill and, if the length does not fit, a compression
// between the two fills; a last compression follows the length words, and the
// digest leaves as four transfers, words a to d, the last flagged. The block
// then restarts from the initial chaining values, ready for a new message.
module md5_message_digest (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  md5_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output md5_pkg::out_t out_data_o
);
  import md5_pkg::*;

  state_e               state_q, state_d, nxt_q, nxt_d;
  logic [5:0]           pos_q, pos_d;
  logic [ByteCntW-1:0]  count_q, count_d;
  logic [AddrW:0]       wptr_q, wptr_d;
  logic                 extra_q, extra_d;
  logic [1:0]           oidx_q, oidx_d;

  wr_t                  wr;
  core_ctl_t            ctl;
  core_sts_t            sts;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [WordW-1:0]     rd_data;
  chain_t               chain;
  logic [63:0]          bit_len;
  logic [AddrW:0]       zero_lim;
  logic [4:0]           lane_sh;

  assign bit_len  = {count_q, 3'b000};
  assign zero_lim = extra_q ? LastZeroLong : LastZeroShort;
  assign lane_sh  = {pos_q[1:0], 3'b000};

  md5_buf_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .chain_o   (chain)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nxt_q   <= ST_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      wptr_q  <= '0;
      extra_q <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      wptr_q  <= wptr_d;
      extra_q <= extra_d;
      oidx_q  <= oidx_d;
    end
  end

  // byte intake, padding sequencer and digest output
  always_comb begin
    state_d     = state_q;
    nxt_d       = nxt_q;
    pos_d       = pos_q;
    count_d     = count_q;
    wptr_d      = wptr_q;
    extra_d     = extra_q;
    oidx_d      = oidx_q;
    wr          = '0;
    ctl         = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          wr.en   = 1'b1;
          wr.addr = pos_q[5:2];
          wr.data = {24'b0, in_data_i.data_byte} << lane_sh;
          wr.be   = 4'b0001 << pos_q[1:0];
          count_d = count_q + 61'd1;
          pos_d   = pos_q + 6'd1;
          if (&pos_q) begin
            // full block: compress, then pad if this was the last byte
            ctl.start = 1'b1;
            state_d   = ST_COMP;
            nxt_d     = in_data_i.end_of_message ? ST_MARK : ST_IDLE;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        wr.en   = 1'b1;
        wr.addr = pos_q[5:2];
        wr.data = {24'b0, PadMark} << lane_sh;
        wr.be   = 4'b1111 << pos_q[1:0];
        // no room for the length after the marker: one more block
        extra_d = &pos_q[5:3];
        wptr_d  = {1'b0, pos_q[5:2]} + 5'd1;
        state_d = ST_ZERO;
      end
      ST_ZERO: begin
        if (wptr_q <= zero_lim) begin
          wr.en   = 1'b1;
          wr.addr = wptr_q[AddrW-1:0];
          wr.data = '0;
          wr.be   = '1;
          wptr_d  = wptr_q + 5'd1;
        end else if (extra_q) begin
          ctl.start = 1'b1;
          state_d   = ST_COMP;
          nxt_d     = ST_ZERO;
          wptr_d    = '0;
          extra_d   = 1'b0;
        end else begin
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        wr.en   = 1'b1;
        wr.addr = LenLoAddr;
        wr.data = bit_len[31:0];
        wr.be   = '1;
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        wr.en     = 1'b1;
        wr.addr   = LenHiAddr;
        wr.data   = bit_len[63:32];
        wr.be     = '1;
        ctl.start = 1'b1;
        state_d   = ST_COMP;
        nxt_d     = ST_OUT;
      end
      ST_COMP: begin
        if (sts.done) begin
          state_d = nxt_q;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == LastWordIdx) begin
            ctl.init = 1'b1;
            pos_d    = '0;
            count_d  = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // digest word select
  assign out_data_o.digest_word = chain[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == LastWordIdx);

  a_no_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && sts.busy)) else $error("byte taken during compression");

  a_buf_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !wr.en) else $error("buffer written during compression");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_word |=>
      in_ready_o && (chain == ChainIv))
    else $error("no clean restart after digest");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the md5 digest block
// Streams messages byte by byte through the input channel and compares each
// digest word on the output channel with a behavioural md5 or a typed-in digest.
// A short stimulus table with a few known digests comes first, then random
// messages of mixed length, including the padding boundary lengths.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][31:0] words_t;  // element 0 is word a

  typedef struct packed {
    logic [7:0] value;
    logic       eom;
    logic       known;
    words_t     digest;
  } stim_row_t;

  localparam words_t ChainStart = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam int unsigned RotTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                         4, 11, 16, 23, 6, 10, 15, 21};

  localparam int NumRows = 10;

  // directed stimulus, digests typed in for the well-known short texts
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{8'h61, 1'b1, 1'b1, {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c}},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190}},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, '0}
  };

  localparam int NumMessages = 10;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  md5_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  md5_pkg::out_t out_data_o;

  // behavioural md5 state
  words_t      chain_words;
  logic [31:0] block_words [16];
  int          block_pos;
  logic [60:0] msg_bytes;

  md5_pkg::out_t digest_words_due [$];
  int            mismatch_count;
  int            idle_pct;
  int            hold_cycles;

  md5_message_digest uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // 64 rounds over the current block, folded into the chaining words
  function automatic void fold_block();
    logic [31:0] a, b, c, d, f, sum, kc, tmp;
    int          g;
    int unsigned rot;
    real         kr;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      // round constant: integer part of |sin(i+1)| * 2^32
      kr = $sin(real'(i + 1));
      if (kr < 0.0) kr = -kr;
      kc  = 32'(longint'($floor(kr * 4294967296.0)));
      rot = RotTab[(i / 16) * 4 + i % 4];
      sum = a + f + kc + block_words[g];
      tmp = d;
      d   = c;
      c   = b;
      b   = b + ((sum << rot) | (sum >> (32 - rot)));
      a   = tmp;
    end
    chain_words[0] = chain_words[0] + a;
    chain_words[1] = chain_words[1] + b;
    chain_words[2] = chain_words[2] + c;
    chain_words[3] = chain_words[3] + d;
  endfunction

  // little-endian byte lane within the block
  function automatic void set_block_byte(int pos, logic [7:0] value);
    block_words[pos / 4][8 * (pos % 4) +: 8] = value;
  endfunction

  function automatic void restart_digest();
    chain_words = ChainStart;
    block_pos   = 0;
    msg_bytes   = '0;
  endfunction

  // take one byte; on the final byte pad, fold and hand back the digest
  function automatic void absorb_byte(input md5_pkg::in_t item, output bit done,
                                      output words_t digest);
    logic [63:0] bit_len;
    int          pos;
    pos = block_pos;
    set_block_byte(pos, item.data_byte);
    msg_bytes = msg_bytes + 61'd1;
    pos++;
    if (pos == 64) begin
      fold_block();
      pos = 0;
    end
    block_pos = pos;
    done      = item.end_of_message;
    digest    = chain_words;
    if (!done) return;
    set_block_byte(pos, 8'h80);
    pos++;
    // no room for the length: zero out this block and start another
    if (64 - pos < 8) begin
      while (pos < 64) begin
        set_block_byte(pos, 8'h00);
        pos++;
      end
      fold_block();
      pos = 0;
    end
    while (pos < 56) begin
      set_block_byte(pos, 8'h00);
      pos++;
    end
    bit_len         = {msg_bytes, 3'b000};
    block_words[14] = bit_len[31:0];
    block_words[15] = bit_len[63:32];
    fold_block();
    digest = chain_words;
    restart_digest();
  endfunction

  // offer one byte from a falling edge, return at the falling edge after the transfer
  task automatic offer_byte(input logic [7:0] value, input logic eom, input bit known,
                            input words_t typed_digest);
    bit            done;
    words_t        predicted;
    md5_pkg::in_t  item;
    md5_pkg::out_t word;
    item.data_byte      = value;
    item.end_of_message = eom;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_byte(item, done, predicted);
    if (done) begin
      for (int k = 0; k < 4; k++) begin
        word.digest_word = known ? typed_digest[k] : predicted[k];
        word.word_index  = 2'(k);
        word.last_word   = (k == 3);
        digest_words_due.push_back(word);
      end
    end
    @(negedge clk_i);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin : result_sink
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // check every result transfer against the oldest expected word
  always @(posedge clk_i) begin
    md5_pkg::out_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_words_due.size() == 0) begin
        $error("unexpected digest transfer: word %h index %0d",
               out_data_o.digest_word, out_data_o.word_index);
        mismatch_count++;
      end else begin
        due = digest_words_due.pop_front();
        if (out_data_o.digest_word !== due.digest_word) begin
          $error("digest_word: expected %h, got %h", due.digest_word, out_data_o.digest_word);
          mismatch_count++;
        end
        if (out_data_o.word_index !== due.word_index) begin
          $error("word_index: expected %0d, got %0d", due.word_index, out_data_o.word_index);
          mismatch_count++;
        end
        if (out_data_o.last_word !== due.last_word) begin
          $error("last_word: expected %0d, got %0d", due.last_word, out_data_o.last_word);
          mismatch_count++;
        end
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    int msg_len;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    mismatch_count = 0;
    idle_pct       = 14;
    hold_cycles    = 0;
    restart_digest();
    for (int w = 0; w < 16; w++) block_words[w] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int r = 0; r < NumRows; r++) begin
      offer_byte(DirectedRows[r].value, DirectedRows[r].eom, DirectedRows[r].known,
                 DirectedRows[r].digest);
    end

    // random messages, an extra pad block and a full block on the final byte
    for (int m = 0; m < NumMessages; m++) begin
      case (m)
        2:       msg_len = 56;
        7:       msg_len = 64;
        default: msg_len = $urandom_range(1, 3);
      endcase
      // long sink hold-off while short messages keep coming
      if (m == 4) hold_cycles <= 400;
      // quiet stretch on both sides
      if (m == 6) idle_pct <= 0;
      // drain everything before carrying on
      if (m == 8) begin
        in_valid_i <= 1'b0;
        wait (digest_words_due.size() == 0);
        @(negedge clk_i);
        idle_pct <= 14;
      end
      for (int n = 0; n < msg_len; n++) begin
        offer_byte(8'($urandom_range(0, 255)), (n == msg_len - 1), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    wait (digest_words_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("md5_message_digest: match");
    end else begin
      $display("md5_message_digest: mismatch");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #1ms;
    $display("md5_message_digest: mismatch");
    $finish;
  end

endmodule
